// File: design/pgha_pkg.sv
// Shared constants and types for the packed gradient/Hessian accumulator.
package pgha_pkg;

    localparam int MAX_PARAMS_DEF = 256;

    localparam int CFG_W      = 9;
    localparam int IDX_W      = 8;
    localparam int VALUE_W    = 48;
    localparam int SUM_W      = 64;
    localparam int ADDR_OUT_W = 16;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CFG_W-1:0] PARAM_COUNT_RESET = 9'd256;

    // Word index of each register on the configuration port.
    localparam logic [APB_AW-3:0] REG_PARAM_COUNT = 1'b0;

    typedef enum logic {
        OP_GRAD = 1'b0,
        OP_HESS = 1'b1
    } op_t;

    typedef struct packed {
        logic en;
        logic hess;
    } mem_ctl_t;

endpackage

// File: design/pgha_item_if.sv
// Input channel carrying one contribution per beat.
interface pgha_item_if;
    import pgha_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      op;
    logic [IDX_W-1:0]          row_index;
    logic [IDX_W-1:0]          col_index;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, op, row_index, col_index, value, input ready);
    modport sink   (input valid, op, row_index, col_index, value, output ready);
endinterface

// File: design/pgha_result_if.sv
// Output channel carrying one accumulated entry per beat.
interface pgha_result_if;
    import pgha_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] sum;
    logic [ADDR_OUT_W-1:0]   address;
    logic                    index_error;

    modport source (output valid, sum, address, index_error, input ready);
    modport sink   (input valid, sum, address, index_error, output ready);
endinterface

// File: design/pgha_store.sv
// Gradient and packed Hessian memories with clearing sweep and write forwarding.
module pgha_store #(
    parameter int MAX_PARAMS = pgha_pkg::MAX_PARAMS_DEF,
    parameter int GA_W       = $clog2(MAX_PARAMS),
    parameter int HA_W       = $clog2(MAX_PARAMS * (MAX_PARAMS + 1) / 2)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pgha_pkg::mem_ctl_t               rd_ctl,
    input  logic [GA_W-1:0]                  rd_gaddr,
    input  logic [HA_W-1:0]                  rd_haddr,
    output logic signed [pgha_pkg::SUM_W-1:0] rd_data,
    input  pgha_pkg::mem_ctl_t               wr_ctl,
    input  logic [GA_W-1:0]                  wr_gaddr,
    input  logic [HA_W-1:0]                  wr_haddr,
    input  logic signed [pgha_pkg::SUM_W-1:0] wr_data,
    output logic                             busy
);
    import pgha_pkg::*;

    localparam int HESS_DEPTH = MAX_PARAMS * (MAX_PARAMS + 1) / 2;
    localparam logic [HA_W-1:0] CLR_LAST = HA_W'(HESS_DEPTH - 1);
    localparam logic [HA_W-1:0] GRAD_END = HA_W'(MAX_PARAMS);

    logic signed [SUM_W-1:0] grad_mem [MAX_PARAMS];
    logic signed [SUM_W-1:0] hess_mem [HESS_DEPTH];

    logic                    clr_busy_reg;
    logic                    clr_busy_next;
    logic [HA_W-1:0]         clr_idx_reg;
    logic [HA_W-1:0]         clr_idx_next;

    logic signed [SUM_W-1:0] grad_q_reg;
    logic signed [SUM_W-1:0] hess_q_reg;
    logic                    rd_hess_reg;
    logic                    fwd_hit_reg;
    logic                    fwd_hit_next;
    logic signed [SUM_W-1:0] fwd_data_reg;

    logic                    grad_we;
    logic [GA_W-1:0]         grad_wa;
    logic signed [SUM_W-1:0] grad_wd;
    logic                    hess_we;
    logic [HA_W-1:0]         hess_wa;
    logic signed [SUM_W-1:0] hess_wd;

    // Zero every entry after reset, one Hessian entry (and one gradient entry) a cycle.
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_idx_next  = clr_idx_reg;
        if (clr_busy_reg)
        begin
            if (clr_idx_reg == CLR_LAST)
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_idx_reg  <= clr_idx_next;
        end
    end

    always_comb
    begin
        if (clr_busy_reg)
        begin
            grad_we = clr_idx_reg < GRAD_END;
            grad_wa = GA_W'(clr_idx_reg);
            grad_wd = '0;
            hess_we = 1'b1;
            hess_wa = clr_idx_reg;
            hess_wd = '0;
        end
        else
        begin
            grad_we = wr_ctl.en && !wr_ctl.hess;
            grad_wa = wr_gaddr;
            grad_wd = wr_data;
            hess_we = wr_ctl.en && wr_ctl.hess;
            hess_wa = wr_haddr;
            hess_wd = wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (grad_we)
        begin
            grad_mem[grad_wa] <= grad_wd;
        end
        if (rd_ctl.en && !rd_ctl.hess)
        begin
            grad_q_reg <= grad_mem[rd_gaddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hess_we)
        begin
            hess_mem[hess_wa] <= hess_wd;
        end
        if (rd_ctl.en && rd_ctl.hess)
        begin
            hess_q_reg <= hess_mem[rd_haddr];
        end
    end

    // A write landing on the same edge as the read returns stale data: capture it instead.
    always_comb
    begin
        fwd_hit_next = wr_ctl.en && (wr_ctl.hess == rd_ctl.hess) &&
                       (rd_ctl.hess ? (wr_haddr == rd_haddr) : (wr_gaddr == rd_gaddr));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
            rd_hess_reg <= 1'b0;
        end
        else if (rd_ctl.en)
        begin
            fwd_hit_reg <= fwd_hit_next;
            rd_hess_reg <= rd_ctl.hess;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_ctl.en)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : (rd_hess_reg ? hess_q_reg : grad_q_reg);
    assign busy    = clr_busy_reg;

endmodule

// File: design/packed_gradient_hessian_accumulator.sv
// Top level: scatter-add of contributions into a gradient vector and packed Hessian.
//
// Each beat on the item channel adds a signed Q24.24 value into one entry: the gradient
// entry row_index (op 0) or the packed upper-triangular Hessian entry of
// (row_index, col_index) (op 1). One beat leaves on the result channel per item with the
// saturated Q40.24 sum after the update and the entry address. An index at or above
// param_count gives index_error, sum 0 and address 0, and changes no entry.
// Items run through a three-register pipeline: packed-address products, memory read, and
// the saturating add into the result register. One item is taken every cycle while the
// result channel does not stall; same-entry items back to back are correct through write
// forwarding in the store.
// After reset both memories are cleared by a sweep over all MAX_PARAMS*(MAX_PARAMS+1)/2
// Hessian entries (32896 at the default size), during which item ready stays low. param_count is written
// over the APB port and resets to 256; it does not clear the stores.
// When the result receiver stalls, the whole pipeline holds and item ready drops in the
// same cycle.
module packed_gradient_hessian_accumulator #(
    parameter int MAX_PARAMS = pgha_pkg::MAX_PARAMS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    pgha_item_if.sink                     item,
    pgha_result_if.source                 result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pgha_pkg::APB_AW-1:0]   paddr,
    input  logic [pgha_pkg::APB_DW-1:0]   pwdata,
    output logic [pgha_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import pgha_pkg::*;

    localparam int HESS_DEPTH = MAX_PARAMS * (MAX_PARAMS + 1) / 2;
    localparam int HA_W = $clog2(HESS_DEPTH);
    localparam int GA_W = $clog2(MAX_PARAMS);
    localparam int N_W  = (CFG_W > $clog2(MAX_PARAMS + 1)) ? CFG_W : $clog2(MAX_PARAMS + 1);
    localparam int P1_W = IDX_W + N_W;
    localparam int P2_W = 2 * IDX_W;
    localparam int AC_W = (P1_W > P2_W) ? P1_W : P2_W;
    localparam logic [N_W-1:0] MAX_N = N_W'(MAX_PARAMS);
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]   acc,
        input logic signed [VALUE_W-1:0] inc
    );
        logic [SUM_W:0] wide;
        wide = {acc[SUM_W-1], acc} + {{(SUM_W+1-VALUE_W){inc[VALUE_W-1]}}, inc};
        if (wide[SUM_W] != wide[SUM_W-1])
        begin
            sat_add = wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sat_add = wide[SUM_W-1:0];
        end
    endfunction

    // Configuration register
    logic [CFG_W-1:0] param_count_reg;
    logic [CFG_W-1:0] param_count_next;
    logic             cfg_sel;

    assign cfg_sel = paddr[APB_AW-1:2] == REG_PARAM_COUNT;

    always_comb
    begin
        param_count_next = param_count_reg;
        if (psel && penable && pwrite && cfg_sel)
        begin
            param_count_next = pwdata[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            param_count_reg <= PARAM_COUNT_RESET;
        end
        else
        begin
            param_count_reg <= param_count_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = cfg_sel ? APB_DW'(param_count_reg) : '0;

    // Pipeline control
    logic store_busy;
    logic advance;
    logic accept;

    logic signed [SUM_W-1:0] res_sum_reg;
    logic [ADDR_OUT_W-1:0]   res_addr_reg;
    logic                    res_err_reg;
    logic                    res_valid_reg;

    assign advance    = !res_valid_reg || result.ready;
    assign item.ready = advance && !store_busy;
    assign accept     = item.valid && item.ready;

    // Stage 1: bound check and packed-address products
    logic [N_W-1:0]   n_cur;
    logic [IDX_W-1:0] lo_idx;
    logic [IDX_W-1:0] hi_idx;
    logic             in_err;

    always_comb
    begin
        n_cur  = (N_W'(param_count_reg) > MAX_N) ? MAX_N : N_W'(param_count_reg);
        lo_idx = (item.row_index < item.col_index) ? item.row_index : item.col_index;
        hi_idx = (item.row_index < item.col_index) ? item.col_index : item.row_index;
        in_err = (N_W'(item.row_index) >= n_cur) ||
                 ((item.op == OP_HESS) && (N_W'(item.col_index) >= n_cur));
    end

    logic                      s1_valid_reg;
    logic                      s1_op_reg;
    logic                      s1_err_reg;
    logic [IDX_W-1:0]          s1_row_reg;
    logic [IDX_W-1:0]          s1_diff_reg;
    logic [P1_W-1:0]           s1_p1_reg;
    logic [P2_W-1:0]           s1_p2_reg;
    logic signed [VALUE_W-1:0] s1_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= item.op;
            s1_err_reg   <= in_err;
            s1_row_reg   <= item.row_index;
            s1_diff_reg  <= hi_idx - lo_idx;
            s1_p1_reg    <= P1_W'(lo_idx) * P1_W'(n_cur);
            s1_p2_reg    <= (P2_W'(lo_idx) * P2_W'(IDX_W'(lo_idx - 1'b1))) >> 1;
            s1_value_reg <= item.value;
        end
    end

    logic [HA_W-1:0]       s1_haddr;
    logic [GA_W-1:0]       s1_gaddr;
    logic [ADDR_OUT_W-1:0] s1_out_addr;
    mem_ctl_t              rd_ctl;

    always_comb
    begin
        s1_haddr    = HA_W'(AC_W'(s1_p1_reg) - AC_W'(s1_p2_reg) + AC_W'(s1_diff_reg));
        s1_gaddr    = GA_W'(s1_row_reg);
        s1_out_addr = (s1_op_reg == OP_HESS) ? ADDR_OUT_W'(s1_haddr) : ADDR_OUT_W'(s1_row_reg);
        rd_ctl.en   = advance && s1_valid_reg && !s1_err_reg;
        rd_ctl.hess = s1_op_reg == OP_HESS;
    end

    // Stage 2: read data back, add and write
    logic                      s2_valid_reg;
    logic                      s2_op_reg;
    logic                      s2_err_reg;
    logic [HA_W-1:0]           s2_haddr_reg;
    logic [GA_W-1:0]           s2_gaddr_reg;
    logic [ADDR_OUT_W-1:0]     s2_out_addr_reg;
    logic signed [VALUE_W-1:0] s2_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_op_reg       <= s1_op_reg;
            s2_err_reg      <= s1_err_reg;
            s2_haddr_reg    <= s1_haddr;
            s2_gaddr_reg    <= s1_gaddr;
            s2_out_addr_reg <= s1_out_addr;
            s2_value_reg    <= s1_value_reg;
        end
    end

    logic signed [SUM_W-1:0] old_sum;
    logic signed [SUM_W-1:0] new_sum;
    mem_ctl_t                wr_ctl;

    always_comb
    begin
        new_sum     = sat_add(old_sum, s2_value_reg);
        wr_ctl.en   = advance && s2_valid_reg && !s2_err_reg;
        wr_ctl.hess = s2_op_reg == OP_HESS;
    end

    pgha_store #(
        .MAX_PARAMS (MAX_PARAMS),
        .GA_W       (GA_W),
        .HA_W       (HA_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_ctl   (rd_ctl),
        .rd_gaddr (s1_gaddr),
        .rd_haddr (s1_haddr),
        .rd_data  (old_sum),
        .wr_ctl   (wr_ctl),
        .wr_gaddr (s2_gaddr_reg),
        .wr_haddr (s2_haddr_reg),
        .wr_data  (new_sum),
        .busy     (store_busy)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_sum_reg  <= s2_err_reg ? '0 : new_sum;
            res_addr_reg <= s2_err_reg ? '0 : s2_out_addr_reg;
            res_err_reg  <= s2_err_reg;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.sum         = res_sum_reg;
    assign result.address     = res_addr_reg;
    assign result.index_error = res_err_reg;

endmodule

// File: tb/pgha_accumulation_checker.sv
// Checker: predicts every accumulated entry and compares it with the result channel; also checks param_count readback.
module pgha_accumulation_checker #(
    parameter int MAX_PARAMS = pgha_pkg::MAX_PARAMS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    pgha_item_if                        item,
    pgha_result_if                      result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pgha_pkg::APB_AW-1:0] paddr,
    input  logic [pgha_pkg::APB_DW-1:0] pwdata,
    input  logic [pgha_pkg::APB_DW-1:0] prdata,
    input  logic                        pready,
    output int                          fail_count,
    output int                          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import pgha_pkg::*;

    localparam int HESS_DEPTH = MAX_PARAMS * (MAX_PARAMS + 1) / 2;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [ADDR_OUT_W-1:0]   address;
        logic                    index_error;
    } entry_result_t;

    entry_result_t           pending_sums[$];
    logic signed [SUM_W-1:0] grad_acc [MAX_PARAMS];
    logic signed [SUM_W-1:0] hess_acc [HESS_DEPTH];
    logic [CFG_W-1:0]        param_count_shadow;

    function automatic logic signed [SUM_W-1:0] saturating_add(
        input logic signed [SUM_W-1:0]   acc,
        input logic signed [VALUE_W-1:0] inc
    );
        logic signed [SUM_W:0] wide;
        wide = {acc[SUM_W-1], acc} + {{(SUM_W-VALUE_W+1){inc[VALUE_W-1]}}, inc};
        // clamp when the carry into the extra bit disagrees with the sign
        if (wide[SUM_W] != wide[SUM_W-1])
            return wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        return wide[SUM_W-1:0];
    endfunction

    function automatic entry_result_t accumulate_contribution(
        input op_t                       op,
        input logic [IDX_W-1:0]          row,
        input logic [IDX_W-1:0]          col,
        input logic signed [VALUE_W-1:0] inc
    );
        entry_result_t res;
        int unsigned   n;
        int unsigned   lo;
        int unsigned   hi;
        int unsigned   addr;
        n = (param_count_shadow > MAX_PARAMS) ? MAX_PARAMS : param_count_shadow;
        res = '0;
        if (row >= n || (op == OP_HESS && col >= n))
        begin
            res.index_error = 1'b1;
            return res;
        end
        if (op == OP_GRAD)
        begin
            addr = row;
            grad_acc[addr % MAX_PARAMS] = saturating_add(grad_acc[addr % MAX_PARAMS], inc);
            res.sum = grad_acc[addr % MAX_PARAMS];
        end
        else
        begin
            lo = (row < col) ? row : col;
            hi = (row < col) ? col : row;
            addr = lo * n - (lo * (lo - 1)) / 2 + (hi - lo);
            hess_acc[addr % HESS_DEPTH] = saturating_add(hess_acc[addr % HESS_DEPTH], inc);
            res.sum = hess_acc[addr % HESS_DEPTH];
        end
        res.address = addr[ADDR_OUT_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        entry_result_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PARAMS; k++)
                grad_acc[k] = '0;
            for (int k = 0; k < HESS_DEPTH; k++)
                hess_acc[k] = '0;
            pending_sums.delete();
            param_count_shadow = PARAM_COUNT_RESET;
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pready && paddr[APB_AW-1:2] == REG_PARAM_COUNT)
            begin
                if (pwrite)
                    param_count_shadow = pwdata[CFG_W-1:0];
                else if (prdata !== APB_DW'(param_count_shadow))
                begin
                    $error("param_count readback: expected %0d actual %0d",
                           param_count_shadow, prdata);
                    fail_count++;
                end
            end

            if (result.valid && result.ready)
            begin
                if (pending_sums.size() == 0)
                begin
                    $error("result beat with no pending entry: sum %0d address %0d",
                           result.sum, result.address);
                    fail_count++;
                end
                else
                begin
                    want = pending_sums.pop_front();
                    if (result.sum !== want.sum)
                    begin
                        $error("sum: expected %0d actual %0d", want.sum, result.sum);
                        fail_count++;
                    end
                    if (result.address !== want.address)
                    begin
                        $error("address: expected %0d actual %0d", want.address,
                               result.address);
                        fail_count++;
                    end
                    if (result.index_error !== want.index_error)
                    begin
                        $error("index_error: expected %0d actual %0d", want.index_error,
                               result.index_error);
                        fail_count++;
                    end
                end
            end

            if (item.valid && item.ready)
                pending_sums.insert(pending_sums.size(),
                                    accumulate_contribution(op_t'(item.op), item.row_index,
                                                            item.col_index, item.value));

            outstanding <= pending_sums.size();
        end
    end

endmodule

// File: tb/packed_gradient_hessian_accumulator_tb.sv
// Top of the accumulator testbench: clock, reset, stimulus and the final verdict.
module packed_gradient_hessian_accumulator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pgha_pkg::*;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic [APB_AW-1:0] PARAM_COUNT_ADDR = {REG_PARAM_COUNT, 2'b00};
    localparam int FULL_SCALE_BEATS = 16;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                fail_count;
    int                outstanding;

    logic              calm = 1'b0;
    int                active_count = PARAM_COUNT_RESET;
    int                items_sent = 0;
    int                settings_written = 0;
    logic [IDX_W-1:0]  last_row = '0;
    logic [IDX_W-1:0]  last_col = '0;

    pgha_item_if   item_ch();
    pgha_result_if result_ch();

    packed_gradient_hessian_accumulator #(
        .MAX_PARAMS(MAX_PARAMS_DEF)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pgha_accumulation_checker #(
        .MAX_PARAMS(MAX_PARAMS_DEF)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item_ch),
        .result      (result_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        result_ch.ready <= calm || ($urandom_range(0, 99) >= 7);

    initial
    begin
        #(20_000_000);
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic take_break();
        return !calm && ($urandom_range(0, 99) < 7);
    endfunction

    task automatic send_item(
        input op_t                       op,
        input logic [IDX_W-1:0]          row,
        input logic [IDX_W-1:0]          col,
        input logic signed [VALUE_W-1:0] val
    );
        while (take_break())
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.op        <= op;
        item_ch.row_index <= row;
        item_ch.col_index <= col;
        item_ch.value     <= val;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Drop valid and hold until every pending result has left the block.
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PARAM_COUNT_ADDR;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_param_count(input logic [CFG_W-1:0] cnt);
        drain();
        repeat (4) @(posedge clk);
        apb_access(1'b1, APB_DW'(cnt));
        apb_access(1'b0, '0);
        active_count = cnt;
        settings_written++;
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        int eff;
        eff = (active_count > MAX_PARAMS_DEF) ? MAX_PARAMS_DEF : active_count;
        if (eff > 0 && $urandom_range(0, 99) < 88)
            return IDX_W'($urandom_range(0, eff - 1));
        return IDX_W'($urandom_range(0, 255));
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int small_val;
        small_val = int'($urandom_range(0, 2000)) - 1000;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return VALUE_MAX;
            2:       return VALUE_MIN;
            3, 4:    return VALUE_W'(small_val);
            default: return VALUE_W'({$urandom, $urandom});
        endcase
    endfunction

    task automatic send_random_items(input int count, input logic pause_midway);
        op_t              op;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        for (int k = 0; k < count; k++)
        begin
            if (pause_midway && k == count / 2)
                drain();
            op = ($urandom_range(0, 2) == 0) ? OP_GRAD : OP_HESS;
            // reuse the previous entry now and then to hit back-to-back updates
            if ($urandom_range(0, 3) == 0)
            begin
                row = $urandom_range(0, 1) ? last_row : last_col;
                col = (row == last_row) ? last_col : last_row;
            end
            else
            begin
                row = pick_index();
                col = pick_index();
            end
            last_row = row;
            last_col = col;
            send_item(op, row, col, pick_value());
        end
    endtask

    initial
    begin
        int counts[10];
        counts = '{256, 2, 17, 300, 1, 128, 255, 0, 64, 256};
        item_ch.valid     <= 1'b0;
        item_ch.op        <= OP_GRAD;
        item_ch.row_index <= '0;
        item_ch.col_index <= '0;
        item_ch.value     <= '0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset count: extremes of both stores, symmetric addressing, readback by zero
        send_item(OP_GRAD, 8'd0,   8'd0,   VALUE_MAX);
        send_item(OP_GRAD, 8'd0,   8'd0,   VALUE_MAX);
        send_item(OP_GRAD, 8'd255, 8'd0,   VALUE_MIN);
        send_item(OP_GRAD, 8'd255, 8'd0,   '0);
        send_item(OP_HESS, 8'd0,   8'd0,   VALUE_MAX);
        send_item(OP_HESS, 8'd255, 8'd255, VALUE_MIN);
        send_item(OP_HESS, 8'd0,   8'd255, 48'sd1);
        send_item(OP_HESS, 8'd255, 8'd0,   -48'sd1);
        send_item(OP_HESS, 8'd17,  8'd200, 48'sh123456789ABC);
        send_item(OP_HESS, 8'd200, 8'd17,  '0);
        send_item(OP_GRAD, 8'd3,   8'd255, 48'sd5);

        // count above capacity acts as the full size
        set_param_count(9'd511);
        send_item(OP_HESS, 8'd255, 8'd255, '0);
        send_item(OP_GRAD, 8'd255, 8'd7,   '0);

        // zero count flags everything
        set_param_count(9'd0);
        send_item(OP_GRAD, 8'd0, 8'd0, VALUE_MAX);
        send_item(OP_HESS, 8'd0, 8'd0, VALUE_MAX);

        // smallest counts: bounds on both indices and the reshaped packed layout
        set_param_count(9'd1);
        send_item(OP_GRAD, 8'd0, 8'd0, '0);
        send_item(OP_GRAD, 8'd1, 8'd0, 48'sd9);
        send_item(OP_HESS, 8'd0, 8'd0, '0);
        send_item(OP_HESS, 8'd0, 8'd1, 48'sd9);
        send_item(OP_HESS, 8'd1, 8'd0, 48'sd9);
        set_param_count(9'd2);
        send_item(OP_HESS, 8'd1, 8'd1, '0);
        send_item(OP_HESS, 8'd0, 8'd1, -48'sd3);

        for (int p = 0; p < 10; p++)
        begin
            set_param_count(CFG_W'(counts[p]));
            calm = (p == 5);
            send_random_items(160, p == 3);
            calm = 1'b0;
        end

        // repeated full-scale increments on one entry of each store
        set_param_count(9'd256);
        for (int k = 0; k < FULL_SCALE_BEATS; k++)
            send_item(OP_GRAD, 8'd7, 8'd0, VALUE_MAX);
        send_item(OP_GRAD, 8'd7, 8'd0, VALUE_MIN);
        send_item(OP_GRAD, 8'd7, 8'd0, '0);
        for (int k = 0; k < FULL_SCALE_BEATS; k++)
            send_item(OP_HESS, 8'd3, 8'd9, VALUE_MIN);
        send_item(OP_HESS, 8'd3, 8'd9, VALUE_MAX);
        send_item(OP_HESS, 8'd9, 8'd3, '0);

        drain();
        repeat (10) @(posedge clk);
        $display("Run: %0d contributions across %0d param_count settings,", items_sent,
                 settings_written);
        $display("with out-of-range indices, layout changes and full-scale same-entry bursts.");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
